/* rtl/core/gnp_pkg.sv */
// ----------------------------------------------------------------------------
// gnp_pkg
// shared widths, codes and defaults of the gradient noise pixel block
// ----------------------------------------------------------------------------
package gnp_pkg;

    // parameter defaults
    localparam int GRID_MAX_DEF       = 15;
    localparam int COORD_BITS_DEF     = 10;
    localparam int GRAD_FRAC_BITS_DEF = 14;

    // fixed field widths
    localparam int TILE_W     = 10;
    localparam int CELL_W     = 4;
    localparam int LAT_IDX_W  = 4;
    localparam int GRAD_IN_W  = 16;
    localparam int GRAY_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // interpolation weight fraction bits (u, v in Q0.16)
    localparam int FRAC_BITS = 16;
    // magnitude bits kept before squaring
    localparam int MAG_W     = 23;

    localparam logic [TILE_W-1:0] TILE_RESET  = TILE_W'(70);
    localparam logic [CELL_W-1:0] CELLS_RESET = CELL_W'(10);
    localparam logic [GRAY_W-1:0] GRAY_MAX    = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TILE_WIDTH   = 2'd0,
        CFG_TILE_HEIGHT  = 2'd1,
        CFG_CELLS_ACROSS = 2'd2,
        CFG_CELLS_DOWN   = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_PIXEL = 1'b1
    } t_action;

    // control that travels with a pixel through the shading pipe
    typedef struct packed {
        logic vld;
        logic oog;
    } t_ctl;

endpackage

/* rtl/core/gnp_div.sv */
// ----------------------------------------------------------------------------
// gnp_div
// pipelined restoring divider, one quotient bit per stage, integer then fraction
// ----------------------------------------------------------------------------
module gnp_div #(
    parameter int NUM_W  = 10,
    parameter int DEN_W  = 10,
    parameter int FRAC_W = 16
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic [NUM_W-1:0]  o_quot,
    output logic [DEN_W-1:0]  o_rem,
    output logic [FRAC_W-1:0] o_frac
);

    localparam int STAGES = NUM_W + FRAC_W;

    logic [NUM_W-1:0]  r_num  [STAGES];
    logic [NUM_W-1:0]  r_quot [STAGES];
    logic [DEN_W-1:0]  r_rem  [STAGES];
    logic [DEN_W-1:0]  r_dx   [STAGES];
    logic [FRAC_W-1:0] r_frac [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [NUM_W-1:0]  num_in;
        logic [NUM_W-1:0]  quot_in;
        logic [DEN_W-1:0]  rem_in;
        logic [DEN_W-1:0]  dx_in;
        logic [FRAC_W-1:0] frac_in;
        logic [DEN_W:0]    trial;
        logic              fits;
        logic [DEN_W-1:0]  n_rem;
        logic [NUM_W-1:0]  n_quot;
        logic [DEN_W-1:0]  n_dx;
        logic [FRAC_W-1:0] n_frac;

        if (k == 0) begin : g_first
            assign num_in  = i_num;
            assign quot_in = '0;
            assign rem_in  = '0;
            assign dx_in   = '0;
            assign frac_in = '0;
        end else begin : g_next
            assign num_in  = r_num[k-1];
            assign quot_in = r_quot[k-1];
            assign rem_in  = r_rem[k-1];
            assign dx_in   = r_dx[k-1];
            assign frac_in = r_frac[k-1];
        end

        // integer bits bring in the dividend, fraction bits bring in zeros
        if (k < NUM_W) begin : g_int
            assign trial = {rem_in, num_in[NUM_W-1-k]};
            always_comb begin
                n_quot = quot_in;
                n_quot[NUM_W-1-k] = fits;
            end
            assign n_dx   = n_rem;
            assign n_frac = frac_in;
        end else begin : g_frac
            assign trial = {rem_in, 1'b0};
            always_comb begin
                n_frac = frac_in;
                n_frac[STAGES-1-k] = fits;
            end
            assign n_quot = quot_in;
            assign n_dx   = dx_in;
        end

        assign fits  = trial >= {1'b0, i_den};
        assign n_rem = fits ? DEN_W'(trial - {1'b0, i_den}) : trial[DEN_W-1:0];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k]  <= num_in;
                r_quot[k] <= n_quot;
                r_rem[k]  <= n_rem;
                r_dx[k]   <= n_dx;
                r_frac[k] <= n_frac;
            end
        end
    end

    assign o_quot = r_quot[STAGES-1];
    assign o_rem  = r_dx[STAGES-1];
    assign o_frac = r_frac[STAGES-1];

endmodule

/* rtl/core/gnp_bank.sv */
// ----------------------------------------------------------------------------
// gnp_bank
// gradient memory bank, one write port and two registered read ports
// ----------------------------------------------------------------------------
module gnp_bank #(
    parameter int ADDR_W = 7,
    parameter int DATA_W = 30
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [DATA_W-1:0] o_rdata_a,
    output logic [DATA_W-1:0] o_rdata_b
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_en) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* rtl/core/gnp_shade.sv */
// ----------------------------------------------------------------------------
// gnp_shade
// corner dot products, bilinear blend, square and scale to a gray level, black out of grid
// ----------------------------------------------------------------------------
module gnp_shade #(
    parameter int GRAD_FRAC_BITS = gnp_pkg::GRAD_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  gnp_pkg::t_ctl                   i_ctl,
    input  logic [2*GRAD_FRAC_BITS+1:0]     i_g_tl,
    input  logic [2*GRAD_FRAC_BITS+1:0]     i_g_tr,
    input  logic [2*GRAD_FRAC_BITS+1:0]     i_g_bl,
    input  logic [2*GRAD_FRAC_BITS+1:0]     i_g_br,
    input  logic [gnp_pkg::TILE_W-1:0]      i_dx,
    input  logic [gnp_pkg::TILE_W-1:0]      i_dy,
    input  logic [gnp_pkg::TILE_W-1:0]      i_tw,
    input  logic [gnp_pkg::TILE_W-1:0]      i_th,
    input  logic [gnp_pkg::FRAC_BITS-1:0]   i_u,
    input  logic [gnp_pkg::FRAC_BITS-1:0]   i_v,
    output gnp_pkg::t_ctl                   o_ctl,
    output logic [gnp_pkg::GRAY_W-1:0]      o_gray
);

    localparam int G_W    = GRAD_FRAC_BITS + 1;
    localparam int FB     = gnp_pkg::FRAC_BITS;
    localparam int OFF_W  = gnp_pkg::TILE_W + 1;
    localparam int PROD_W = OFF_W + G_W;
    localparam int DOT_W  = PROD_W + 1;
    localparam int WT_W   = FB + 2;
    localparam int LPP_W  = DOT_W + WT_W;
    localparam int LP_W   = DOT_W + FB + 1;
    localparam int PP_W   = LP_W + WT_W;
    localparam int P_W    = LP_W + FB + 1;
    localparam int P_FRAC = GRAD_FRAC_BITS + 2 * FB;
    localparam int M_W    = gnp_pkg::MAG_W;
    localparam int SQ_W   = 2 * M_W;
    localparam int SC_W   = SQ_W + gnp_pkg::GRAY_W;
    localparam int STAGES = 9;

    logic signed [OFF_W-1:0]  ox0, ox1, oy0, oy1;
    logic signed [G_W-1:0]    gx [4];
    logic signed [G_W-1:0]    gy [4];
    logic signed [WT_W-1:0]   wu, wu1, wv, wv1;
    logic [P_W-1:0]           mag;
    logic [SC_W-1:0]          scaled;

    gnp_pkg::t_ctl            r_ctl [STAGES];
    logic [FB-1:0]            r_u   [2];
    logic [FB-1:0]            r_v   [4];
    logic signed [PROD_W-1:0] r_px  [4];
    logic signed [PROD_W-1:0] r_py  [4];
    logic signed [DOT_W-1:0]  r_dot [4];
    logic signed [LPP_W-1:0]  r_lp  [4];
    logic signed [LP_W-1:0]   r_top, r_bot;
    logic signed [PP_W-1:0]   r_pp  [2];
    logic signed [P_W-1:0]    r_p;
    logic                     r_sat7, r_sat8;
    logic [M_W-1:0]           r_m;
    logic [SQ_W-1:0]          r_sq;
    logic [gnp_pkg::GRAY_W-1:0] r_gray;

    // corner offsets (dx, dx - tw) and (dy, dy - th)
    assign ox0 = $signed({1'b0, i_dx});
    assign ox1 = ox0 - $signed({1'b0, i_tw});
    assign oy0 = $signed({1'b0, i_dy});
    assign oy1 = oy0 - $signed({1'b0, i_th});

    always_comb begin
        gx[0] = $signed(i_g_tl[2*G_W-1:G_W]);
        gy[0] = $signed(i_g_tl[G_W-1:0]);
        gx[1] = $signed(i_g_tr[2*G_W-1:G_W]);
        gy[1] = $signed(i_g_tr[G_W-1:0]);
        gx[2] = $signed(i_g_bl[2*G_W-1:G_W]);
        gy[2] = $signed(i_g_bl[G_W-1:0]);
        gx[3] = $signed(i_g_br[2*G_W-1:G_W]);
        gy[3] = $signed(i_g_br[G_W-1:0]);
    end

    // blend weights w and 1 - w
    assign wu  = $signed({2'b00, r_u[1]});
    assign wu1 = $signed(WT_W'(1) << FB) - wu;
    assign wv  = $signed({2'b00, r_v[3]});
    assign wv1 = $signed(WT_W'(1) << FB) - wv;

    assign mag    = r_p[P_W-1] ? P_W'(-r_p) : P_W'(r_p);
    // m * m * 255 as (m * m << 8) - m * m
    assign scaled = {r_sq, gnp_pkg::GRAY_W'(0)} - {gnp_pkg::GRAY_W'(0), r_sq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STAGES; k++) begin
                r_ctl[k] <= '0;
            end
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
            for (int k = 1; k < STAGES; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // offset times gradient component
            r_px[0] <= ox0 * gx[0];
            r_py[0] <= oy0 * gy[0];
            r_px[1] <= ox1 * gx[1];
            r_py[1] <= oy0 * gy[1];
            r_px[2] <= ox0 * gx[2];
            r_py[2] <= oy1 * gy[2];
            r_px[3] <= ox1 * gx[3];
            r_py[3] <= oy1 * gy[3];
            r_u[0]  <= i_u;
            r_u[1]  <= r_u[0];
            r_v[0]  <= i_v;
            r_v[1]  <= r_v[0];
            r_v[2]  <= r_v[1];
            r_v[3]  <= r_v[2];
            // corner dots
            for (int k = 0; k < 4; k++) begin
                r_dot[k] <= DOT_W'(r_px[k]) + DOT_W'(r_py[k]);
            end
            // horizontal blend
            r_lp[0] <= r_dot[0] * wu1;
            r_lp[1] <= r_dot[1] * wu;
            r_lp[2] <= r_dot[2] * wu1;
            r_lp[3] <= r_dot[3] * wu;
            r_top   <= LP_W'(r_lp[0] + r_lp[1]);
            r_bot   <= LP_W'(r_lp[2] + r_lp[3]);
            // vertical blend
            r_pp[0] <= r_top * wv1;
            r_pp[1] <= r_bot * wv;
            r_p     <= P_W'(r_pp[0] + r_pp[1]);
            // magnitude, saturation at one
            r_sat7  <= |mag[P_W-1:P_FRAC];
            r_m     <= mag[P_FRAC-1 -: M_W];
            r_sq    <= SQ_W'(r_m) * SQ_W'(r_m);
            r_sat8  <= r_sat7;
            if (r_ctl[7].oog) begin
                r_gray <= '0;
            end else if (r_sat8) begin
                r_gray <= gnp_pkg::GRAY_MAX;
            end else begin
                r_gray <= scaled[SC_W-1 -: gnp_pkg::GRAY_W];
            end
        end
    end

    assign o_ctl  = r_ctl[STAGES-1];
    assign o_gray = r_gray;

endmodule

/* rtl/core/gradient_noise_pixel.sv */
// ----------------------------------------------------------------------------
// gradient_noise_pixel
// throughput: one beat per cycle while o_stall is low, loads and pixels alike
// path: divider pipe (COORD_BITS + 16 stages), memory read, shading pipe, output register
// reset: synchronous active low; config back to 70/70/10/10, pipe emptied,
// gradient table is not cleared and must be loaded before it is read
// ----------------------------------------------------------------------------
module gradient_noise_pixel #(
    parameter int GRID_MAX       = gnp_pkg::GRID_MAX_DEF,
    parameter int COORD_BITS     = gnp_pkg::COORD_BITS_DEF,
    parameter int GRAD_FRAC_BITS = gnp_pkg::GRAD_FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_action,
    input  logic [gnp_pkg::LAT_IDX_W-1:0]        i_lattice_row,
    input  logic [gnp_pkg::LAT_IDX_W-1:0]        i_lattice_col,
    input  logic signed [gnp_pkg::GRAD_IN_W-1:0] i_grad_x,
    input  logic signed [gnp_pkg::GRAD_IN_W-1:0] i_grad_y,
    input  logic [COORD_BITS-1:0]                i_pixel_x,
    input  logic [COORD_BITS-1:0]                i_pixel_y,
    // output channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [gnp_pkg::GRAY_W-1:0]           o_gray,
    output logic                                 o_out_of_grid,
    // configuration writes
    input  logic                                 i_cfg_we,
    input  logic [gnp_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [gnp_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int G_W       = GRAD_FRAC_BITS + 1;
    localparam int ENT_W     = 2 * G_W;
    // lattice column bits, rows split over two banks by parity
    localparam int CB        = (GRID_MAX > 1) ? $clog2(GRID_MAX + 1) : 1;
    localparam int HALF_ROWS = (GRID_MAX + 2) / 2;
    localparam int RH_W      = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;
    localparam int ADDR_W    = RH_W + CB;
    localparam int DIV_ST    = COORD_BITS + gnp_pkg::FRAC_BITS;
    localparam int CMP_W     = (COORD_BITS > 6) ? COORD_BITS : 6;
    localparam int TW        = gnp_pkg::TILE_W;
    localparam int FB        = gnp_pkg::FRAC_BITS;

    typedef struct packed {
        logic                          vld;
        logic                          pix;
        logic [gnp_pkg::LAT_IDX_W-1:0] lrow;
        logic [gnp_pkg::LAT_IDX_W-1:0] lcol;
        logic [ENT_W-1:0]              grad;
    } t_side;

    // saturate a loaded component to the stored Q1.GRAD_FRAC_BITS range
    function automatic logic [G_W-1:0] sat_grad(input logic signed [gnp_pkg::GRAD_IN_W-1:0] val);
        int v;
        int hi;
        v  = int'(val);
        hi = 1 << GRAD_FRAC_BITS;
        if (v > hi - 1) begin
            v = hi - 1;
        end
        if (v < -hi) begin
            v = -hi;
        end
        return G_W'(v);
    endfunction

    // config registers
    logic [TW-1:0]              r_tile_w, r_tile_h;
    logic [gnp_pkg::CELL_W-1:0] r_cells_a, r_cells_d;
    logic [TW-1:0]              tw_eff, th_eff;
    logic [CMP_W-1:0]           ca_eff, cd_eff;

    // handshake and pipe advance
    logic   accept;
    logic   en;
    t_side  in_side;
    t_side  r_side [DIV_ST];

    // divider outputs
    logic [COORD_BITS-1:0] col, row;
    logic [TW-1:0]         dx, dy;
    logic [FB-1:0]         u, v;

    // memory addressing at the end of the divider pipe
    t_side             d_side;
    logic              oog;
    logic [CB-1:0]     col_lo, colp1, row_lo;
    logic [RH_W-1:0]   half0, half1, whalf;
    logic [ADDR_W-1:0] waddr;
    logic              wr, we0, we1;
    logic [ENT_W-1:0]  b0_a, b0_b, b1_a, b1_b;

    // stage after the memory read
    gnp_pkg::t_ctl     r_m_ctl;
    logic              r_m_odd;
    logic [TW-1:0]     r_m_dx, r_m_dy;
    logic [FB-1:0]     r_m_u, r_m_v;
    logic [ENT_W-1:0]  g_tl, g_tr, g_bl, g_br;

    // shading output, output register and skid
    gnp_pkg::t_ctl              s_ctl;
    logic [gnp_pkg::GRAY_W-1:0] s_gray;
    logic                       r_ovld, r_svld;
    logic [gnp_pkg::GRAY_W-1:0] r_ogray, r_sgray;
    logic                       r_ooog, r_soog;
    logic                       take;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_w  <= gnp_pkg::TILE_RESET;
            r_tile_h  <= gnp_pkg::TILE_RESET;
            r_cells_a <= gnp_pkg::CELLS_RESET;
            r_cells_d <= gnp_pkg::CELLS_RESET;
        end else if (i_cfg_we) begin
            case (gnp_pkg::t_cfg_idx'(i_cfg_idx))
                gnp_pkg::CFG_TILE_WIDTH:   r_tile_w  <= TW'(i_cfg_data);
                gnp_pkg::CFG_TILE_HEIGHT:  r_tile_h  <= TW'(i_cfg_data);
                gnp_pkg::CFG_CELLS_ACROSS: r_cells_a <= i_cfg_data[gnp_pkg::CELL_W-1:0];
                gnp_pkg::CFG_CELLS_DOWN:   r_cells_d <= i_cfg_data[gnp_pkg::CELL_W-1:0];
                default: ;
            endcase
        end
    end

    // a zero tile size acts as one, cell counts clip to the lattice
    assign tw_eff = (r_tile_w == '0) ? TW'(1) : r_tile_w;
    assign th_eff = (r_tile_h == '0) ? TW'(1) : r_tile_h;
    assign ca_eff = (int'(r_cells_a) > GRID_MAX) ? CMP_W'(GRID_MAX) : CMP_W'(r_cells_a);
    assign cd_eff = (int'(r_cells_d) > GRID_MAX) ? CMP_W'(GRID_MAX) : CMP_W'(r_cells_d);

    // ------------------------------------------------------------------
    // input beat; the whole pipe moves unless the skid holds a result
    // ------------------------------------------------------------------
    assign en      = !r_svld;
    assign o_stall = r_svld;
    assign accept  = i_valid && en;

    always_comb begin
        in_side.vld  = accept;
        in_side.pix  = (i_action == gnp_pkg::ACT_PIXEL);
        in_side.lrow = i_lattice_row;
        in_side.lcol = i_lattice_col;
        in_side.grad = {sat_grad(i_grad_x), sat_grad(i_grad_y)};
    end

    // load beats ride alongside the divider so table writes keep beat order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_ST; k++) begin
                r_side[k].vld <= 1'b0;
            end
        end else if (en) begin
            r_side[0] <= in_side;
            for (int k = 1; k < DIV_ST; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // tile divide: col, dx, u on x and row, dy, v on y
    // ------------------------------------------------------------------
    gnp_div #(
        .NUM_W  (COORD_BITS),
        .DEN_W  (TW),
        .FRAC_W (FB)
    ) u_div_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (i_pixel_x),
        .i_den  (tw_eff),
        .o_quot (col),
        .o_rem  (dx),
        .o_frac (u)
    );

    gnp_div #(
        .NUM_W  (COORD_BITS),
        .DEN_W  (TW),
        .FRAC_W (FB)
    ) u_div_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (i_pixel_y),
        .i_den  (th_eff),
        .o_quot (row),
        .o_rem  (dy),
        .o_frac (v)
    );

    // ------------------------------------------------------------------
    // gradient table: bank 0 holds even rows, bank 1 odd rows, so the
    // four corners of a cell land on two read ports of each bank
    // ------------------------------------------------------------------
    assign d_side = r_side[DIV_ST-1];
    assign oog    = (CMP_W'(col) >= ca_eff) || (CMP_W'(row) >= cd_eff);
    assign col_lo = col[CB-1:0];
    assign row_lo = row[CB-1:0];
    assign colp1  = CB'(col_lo + 1'b1);
    // even bank serves row or row + 1, whichever is even
    assign half0  = RH_W'(({1'b0, row_lo} + (CB + 1)'(row_lo[0])) >> 1);
    assign half1  = RH_W'(row_lo >> 1);

    // loads beyond the lattice are dropped
    assign wr     = en && d_side.vld && !d_side.pix &&
                    (int'(d_side.lrow) <= GRID_MAX) && (int'(d_side.lcol) <= GRID_MAX);
    assign whalf  = RH_W'(d_side.lrow >> 1);
    assign waddr  = {whalf, CB'(d_side.lcol)};
    assign we0    = wr && !d_side.lrow[0];
    assign we1    = wr && d_side.lrow[0];

    gnp_bank #(
        .ADDR_W (ADDR_W),
        .DATA_W (ENT_W)
    ) u_bank_even (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_we      (we0),
        .i_waddr   (waddr),
        .i_wdata   (d_side.grad),
        .i_raddr_a ({half0, col_lo}),
        .i_raddr_b ({half0, colp1}),
        .o_rdata_a (b0_a),
        .o_rdata_b (b0_b)
    );

    gnp_bank #(
        .ADDR_W (ADDR_W),
        .DATA_W (ENT_W)
    ) u_bank_odd (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_we      (we1),
        .i_waddr   (waddr),
        .i_wdata   (d_side.grad),
        .i_raddr_a ({half1, col_lo}),
        .i_raddr_b ({half1, colp1}),
        .o_rdata_a (b1_a),
        .o_rdata_b (b1_b)
    );

    // pixel data that waits out the memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_ctl <= '0;
        end else if (en) begin
            r_m_ctl.vld <= d_side.vld && d_side.pix;
            r_m_ctl.oog <= oog;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_odd <= row_lo[0];
            r_m_dx  <= dx;
            r_m_dy  <= dy;
            r_m_u   <= u;
            r_m_v   <= v;
        end
    end

    // odd cell rows take their top corners from the odd bank
    assign g_tl = r_m_odd ? b1_a : b0_a;
    assign g_tr = r_m_odd ? b1_b : b0_b;
    assign g_bl = r_m_odd ? b0_a : b1_a;
    assign g_br = r_m_odd ? b0_b : b1_b;

    gnp_shade #(
        .GRAD_FRAC_BITS (GRAD_FRAC_BITS)
    ) u_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (r_m_ctl),
        .i_g_tl  (g_tl),
        .i_g_tr  (g_tr),
        .i_g_bl  (g_bl),
        .i_g_br  (g_br),
        .i_dx    (r_m_dx),
        .i_dy    (r_m_dy),
        .i_tw    (tw_eff),
        .i_th    (th_eff),
        .i_u     (r_m_u),
        .i_v     (r_m_v),
        .o_ctl   (s_ctl),
        .o_gray  (s_gray)
    );

    // ------------------------------------------------------------------
    // output register with a one-beat skid; the pipe freezes only while
    // the skid is full
    // ------------------------------------------------------------------
    assign take = r_ovld && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
            r_svld <= 1'b0;
        end else begin
            if (take || !r_ovld) begin
                if (r_svld) begin
                    r_ovld  <= 1'b1;
                    r_ogray <= r_sgray;
                    r_ooog  <= r_soog;
                    r_svld  <= 1'b0;
                end else if (en && s_ctl.vld) begin
                    r_ovld  <= 1'b1;
                    r_ogray <= s_gray;
                    r_ooog  <= s_ctl.oog;
                end else begin
                    r_ovld  <= 1'b0;
                end
            end else if (en && s_ctl.vld) begin
                // output held, park the new result
                r_svld  <= 1'b1;
                r_sgray <= s_gray;
                r_soog  <= s_ctl.oog;
            end
        end
    end

    assign o_valid       = r_ovld;
    assign o_gray        = r_ogray;
    assign o_out_of_grid = r_ooog;

endmodule

/* rtl/core/gnp_checker.sv */
// ----------------------------------------------------------------------------
// gnp_checker
// port-level checks for the gradient noise pixel block
// ----------------------------------------------------------------------------
module gnp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [gnp_pkg::GRAY_W-1:0]  o_gray,
    input logic                        o_out_of_grid
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_gray) && $stable(o_out_of_grid))
        else $error("result beat changed under stall");

    // pixels outside the lattice are black
    a_oog_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_grid |-> o_gray == '0)
        else $error("out of grid result with nonzero gray");

    // input is held off only while a result waits behind a held output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result waiting");

    a_stall_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stall without a held output");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("result beat right after reset");

endmodule

bind gradient_noise_pixel gnp_checker u_gnp_checker (.*);
